FILE: hdl/gap_pkg.sv
// Shared types and codes for the grid path search block.
`timescale 1ns / 1ps

package gap_pkg;

  // Input item opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_FOUND    = 2'd0;
  localparam logic [1:0] STATUS_NO_PATH  = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // Neighbor directions, in expansion order
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SEED,
    ST_POP,
    ST_POP_WAIT,
    ST_CUR_RD,
    ST_CUR_WR,
    ST_NB_RD,
    ST_NB_CHK,
    ST_PUSH_WAIT,
    ST_BT_GOAL,
    ST_BT_RD,
    ST_BT_CHK,
    ST_BT_TURN,
    ST_BT_ADV,
    ST_BT_START,
    ST_STATUS
  } gap_state_e;

  typedef enum logic [2:0] {
    H_IDLE,
    H_UP_RD,
    H_UP_CMP,
    H_PLACE,
    H_POP_RD,
    H_DN_RD,
    H_DN_CMP
  } gap_hstate_e;

  typedef struct packed {
    logic       clear;
    logic       push;
    logic       pop;
  } gap_heap_cmd_t;

  typedef struct packed {
    logic       idle;
    logic       empty;
    logic       full;
  } gap_heap_sts_t;

  typedef struct packed {
    logic       opcode;
    logic [3:0] cell_row;
    logic [3:0] cell_col;
    logic       cell_blocked;
    logic [3:0] start_row;
    logic [3:0] start_col;
    logic [3:0] goal_row;
    logic [3:0] goal_col;
  } gap_req_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] point_row;
    logic [3:0] point_col;
    logic [1:0] status;
    logic       last;
  } gap_res_t;

endpackage

FILE: hdl/gap_if.sv
// Valid/ready channel interfaces for search requests and path results.
`timescale 1ns / 1ps

interface gap_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [3:0] cell_row;
  logic [3:0] cell_col;
  logic       cell_blocked;
  logic [3:0] start_row;
  logic [3:0] start_col;
  logic [3:0] goal_row;
  logic [3:0] goal_col;

  modport source (
    output valid, opcode, cell_row, cell_col, cell_blocked,
           start_row, start_col, goal_row, goal_col,
    input  ready
  );
  modport sink (
    input  valid, opcode, cell_row, cell_col, cell_blocked,
           start_row, start_col, goal_row, goal_col,
    output ready
  );
endinterface

interface gap_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] point_row;
  logic [3:0] point_col;
  logic [1:0] status;
  logic       last;

  modport source (
    output valid, point_row, point_col, status, last,
    input  ready
  );
  modport sink (
    input  valid, point_row, point_col, status, last,
    output ready
  );
endinterface

FILE: hdl/gap_heap.sv
// Binary min-heap on f in a two-read, one-write memory with a sift sequencer.
`timescale 1ns / 1ps

module gap_heap #(
  parameter int DEPTH  = 1024,
  parameter int F_W    = 10,
  parameter int CELL_W = 8,
  localparam int EW    = F_W + CELL_W,
  localparam int IW    = $clog2(DEPTH),
  localparam int CNT_W = IW + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gap_pkg::gap_heap_cmd_t cmd_i,
  input  logic [EW-1:0]         wdata_i,
  output logic [CELL_W-1:0]     root_o,
  output gap_pkg::gap_heap_sts_t sts_o
);

  gap_pkg::gap_hstate_e state_q, state_d;

  logic [CNT_W-1:0]  count_q;
  logic [IW-1:0]     i_q;
  logic [EW-1:0]     item_q;
  logic [CELL_W-1:0] root_q;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rda_q, rdb_q;
  logic [IW-1:0] ra, rb, wa;
  logic [EW-1:0] wd;
  logic          we;

  logic [IW-1:0]  parent;
  logic [IW+1:0]  l_x, r_x, cnt_x;
  logic           pick_r;
  logic [EW-1:0]  s_ent;
  logic [IW-1:0]  s_idx;
  logic           up_less, dn_stop;

  assign parent = (i_q - IW'(1)) >> 1;
  assign l_x    = {1'b0, i_q, 1'b1};
  assign r_x    = l_x + (IW+2)'(1);
  assign cnt_x  = (IW+2)'(count_q);
  assign pick_r = (r_x < cnt_x) && (rdb_q[EW-1 -: F_W] < rda_q[EW-1 -: F_W]);
  assign s_ent  = pick_r ? rdb_q : rda_q;
  assign s_idx  = pick_r ? r_x[IW-1:0] : l_x[IW-1:0];
  assign up_less = item_q[EW-1 -: F_W] < rda_q[EW-1 -: F_W];
  assign dn_stop = item_q[EW-1 -: F_W] < s_ent[EW-1 -: F_W];

  assign root_o      = root_q;
  assign sts_o.idle  = (state_q == gap_pkg::H_IDLE);
  assign sts_o.empty = (count_q == '0);
  assign sts_o.full  = (count_q == CNT_W'(DEPTH));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gap_pkg::H_IDLE: begin
        if (cmd_i.clear) begin
          state_d = gap_pkg::H_IDLE;
        end else if (cmd_i.push) begin
          state_d = (count_q == '0) ? gap_pkg::H_IDLE : gap_pkg::H_UP_RD;
        end else if (cmd_i.pop) begin
          state_d = gap_pkg::H_POP_RD;
        end
      end
      gap_pkg::H_UP_RD:  state_d = gap_pkg::H_UP_CMP;
      gap_pkg::H_UP_CMP: begin
        if (up_less && parent != '0) begin
          state_d = gap_pkg::H_UP_RD;
        end else begin
          state_d = gap_pkg::H_PLACE;
        end
      end
      gap_pkg::H_PLACE:  state_d = gap_pkg::H_IDLE;
      gap_pkg::H_POP_RD: state_d = (count_q == '0) ? gap_pkg::H_IDLE : gap_pkg::H_DN_RD;
      gap_pkg::H_DN_RD:  state_d = (l_x >= cnt_x) ? gap_pkg::H_PLACE : gap_pkg::H_DN_CMP;
      gap_pkg::H_DN_CMP: state_d = dn_stop ? gap_pkg::H_PLACE : gap_pkg::H_DN_RD;
      default:           state_d = gap_pkg::H_IDLE;
    endcase
  end

  // memory ports
  always_comb begin
    ra = '0;
    rb = count_q[IW-1:0] - IW'(1);
    we = 1'b0;
    wa = i_q;
    wd = item_q;
    case (state_q)
      gap_pkg::H_IDLE: begin
        if (!cmd_i.clear && cmd_i.push) begin
          we = 1'b1;
          wa = count_q[IW-1:0];
          wd = wdata_i;
        end
      end
      gap_pkg::H_UP_RD: ra = parent;
      gap_pkg::H_UP_CMP: begin
        if (up_less) begin
          we = 1'b1;
          wd = rda_q;
        end
      end
      gap_pkg::H_PLACE: we = 1'b1;
      gap_pkg::H_DN_RD: begin
        ra = l_x[IW-1:0];
        rb = r_x[IW-1:0];
      end
      gap_pkg::H_DN_CMP: begin
        if (!dn_stop) begin
          we = 1'b1;
          wd = s_ent;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rda_q <= mem[ra];
    rdb_q <= mem[rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gap_pkg::H_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == gap_pkg::H_IDLE) begin
        if (cmd_i.clear) begin
          count_q <= '0;
        end else if (cmd_i.push) begin
          count_q <= count_q + CNT_W'(1);
        end else if (cmd_i.pop) begin
          count_q <= count_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      gap_pkg::H_IDLE: begin
        if (cmd_i.push) begin
          item_q <= wdata_i;
          i_q    <= count_q[IW-1:0];
        end
      end
      gap_pkg::H_UP_CMP: begin
        if (up_less) begin
          i_q <= parent;
        end
      end
      gap_pkg::H_POP_RD: begin
        root_q <= rda_q[CELL_W-1:0];
        item_q <= rdb_q;
        i_q    <= '0;
      end
      gap_pkg::H_DN_CMP: begin
        if (!dn_stop) begin
          i_q <= s_idx;
        end
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("heap count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gap_pkg::H_IDLE && cmd_i.push && !cmd_i.clear) |-> !sts_o.full)
    else $error("push into full heap");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gap_pkg::H_IDLE && cmd_i.pop && !cmd_i.push && !cmd_i.clear)
    |-> !sts_o.empty)
    else $error("pop from empty heap");

endmodule

FILE: hdl/gap_search.sv
// Search sequencer: grid and node memories, A* expansion and path backtrack.
`timescale 1ns / 1ps

module gap_search #(
  parameter int GRID_ROWS       = 16,
  parameter int GRID_COLS       = 16,
  parameter int MAX_TURN_POINTS = 25,
  localparam int RW     = $clog2(GRID_ROWS),
  localparam int CW     = $clog2(GRID_COLS),
  localparam int AW     = RW + CW,
  localparam int CELLS  = GRID_ROWS * GRID_COLS,
  localparam int COST_W = $clog2(CELLS) + 1,
  localparam int F_W    = COST_W + 1,
  localparam int EW     = F_W + AW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gap_pkg::gap_req_t      req_i,
  input  logic                   req_valid_i,
  output logic                   req_ready_o,
  output gap_pkg::gap_res_t      res_o,
  input  logic                   res_ready_i,
  output gap_pkg::gap_heap_cmd_t heap_cmd_o,
  output logic [EW-1:0]          heap_wdata_o,
  input  logic [AW-1:0]          heap_root_i,
  input  gap_pkg::gap_heap_sts_t heap_sts_i
);

  localparam int MEM_D = 2 ** AW;
  localparam int NDW   = 1 + COST_W + AW;
  localparam int SW    = $clog2(CELLS + 1);
  localparam int TW    = $clog2(MAX_TURN_POINTS + 1);
  localparam logic [COST_W-1:0] COST_INF = '1;

  gap_pkg::gap_state_e state_q, state_d;

  logic [AW-1:0]     idx_q, start_q, goal_q, cur_q, nb_q, prev_q;
  logic [COST_W-1:0] gcur_q;
  logic [1:0]        d_q;
  logic [F_W-1:0]    f_q;
  logic [1:0]        status_q;
  logic              xf_q, yf_q;
  logic [TW-1:0]     n_q;
  logic [SW-1:0]     steps_q;

  logic              grid_mem [MEM_D];
  logic              grid_rd_q;
  logic              grid_we, grid_wd;
  logic [AW-1:0]     grid_wa;

  logic [NDW-1:0]    node_mem [MEM_D];
  logic [NDW-1:0]    node_rd_q, node_wd;
  logic              node_we;
  logic [AW-1:0]     node_wa, node_ra;

  logic              rd_closed;
  logic [COST_W-1:0] rd_cost;
  logic [AW-1:0]     rd_pred;

  logic [RW-1:0] cur_r, nb_r;
  logic [CW-1:0] cur_c, nb_c;
  logic          nb_ok;
  logic [AW-1:0] nb_addr;
  logic [COST_W-1:0] g_new;
  logic          relax, last_dir;
  logic          same_row, same_col, emit_turn, xf_n, yf_n;

  logic [7:0] cr8, cc8, sr8, sc8, gr8, gc8;
  logic       load_ok, off_grid, accept;
  logic [AW-1:0] s_addr, g_addr;

  function automatic logic [F_W-1:0] manh(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [RW-1:0] ar, br, dr;
    logic [CW-1:0] ac, bc, dc;
    begin
      ar = a[AW-1 -: RW];
      br = b[AW-1 -: RW];
      ac = a[CW-1:0];
      bc = b[CW-1:0];
      dr = (ar > br) ? ar - br : br - ar;
      dc = (ac > bc) ? ac - bc : bc - ac;
      return F_W'(dr) + F_W'(dc);
    end
  endfunction

  assign cr8 = 8'(req_i.cell_row);
  assign cc8 = 8'(req_i.cell_col);
  assign sr8 = 8'(req_i.start_row);
  assign sc8 = 8'(req_i.start_col);
  assign gr8 = 8'(req_i.goal_row);
  assign gc8 = 8'(req_i.goal_col);
  assign load_ok  = (cr8 < 8'(GRID_ROWS)) && (cc8 < 8'(GRID_COLS));
  assign off_grid = (sr8 >= 8'(GRID_ROWS)) || (sc8 >= 8'(GRID_COLS)) ||
                    (gr8 >= 8'(GRID_ROWS)) || (gc8 >= 8'(GRID_COLS));
  assign s_addr   = {sr8[RW-1:0], sc8[CW-1:0]};
  assign g_addr   = {gr8[RW-1:0], gc8[CW-1:0]};
  assign accept   = req_valid_i && (state_q == gap_pkg::ST_IDLE);

  assign rd_closed = node_rd_q[NDW-1];
  assign rd_cost   = node_rd_q[NDW-2 -: COST_W];
  assign rd_pred   = node_rd_q[AW-1:0];

  assign cur_r = cur_q[AW-1 -: RW];
  assign cur_c = cur_q[CW-1:0];

  always_comb begin
    nb_ok = 1'b0;
    nb_r  = cur_r;
    nb_c  = cur_c;
    case (d_q)
      gap_pkg::DIR_UP: begin
        nb_ok = (cur_r != '0);
        nb_r  = cur_r - RW'(1);
      end
      gap_pkg::DIR_DOWN: begin
        nb_ok = (cur_r != RW'(GRID_ROWS - 1));
        nb_r  = cur_r + RW'(1);
      end
      gap_pkg::DIR_LEFT: begin
        nb_ok = (cur_c != '0);
        nb_c  = cur_c - CW'(1);
      end
      gap_pkg::DIR_RIGHT: begin
        nb_ok = (cur_c != CW'(GRID_COLS - 1));
        nb_c  = cur_c + CW'(1);
      end
      default: ;
    endcase
  end

  assign nb_addr  = {nb_r, nb_c};
  assign last_dir = (d_q == gap_pkg::DIR_RIGHT);
  assign g_new    = gcur_q + COST_W'(1);
  assign relax    = !grid_rd_q && !rd_closed && (g_new < rd_cost);

  // turn detection on the backtrack
  assign same_row = (rd_pred[AW-1 -: RW] == cur_r);
  assign same_col = (rd_pred[CW-1:0] == cur_c);
  always_comb begin
    xf_n      = xf_q;
    yf_n      = yf_q;
    emit_turn = 1'b0;
    if (!xf_q && !yf_q) begin
      if (same_row) begin
        yf_n = 1'b1;
      end else if (same_col) begin
        xf_n = 1'b1;
      end
    end else if (same_col) begin
      if (!xf_q) begin
        emit_turn = (n_q < TW'(MAX_TURN_POINTS - 1));
        yf_n      = 1'b0;
        xf_n      = 1'b1;
      end
    end else if (same_row) begin
      if (!yf_q) begin
        emit_turn = (n_q < TW'(MAX_TURN_POINTS - 1));
        yf_n      = 1'b1;
        xf_n      = 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gap_pkg::ST_INIT: begin
        if (idx_q == '1) state_d = gap_pkg::ST_IDLE;
      end
      gap_pkg::ST_IDLE: begin
        if (req_valid_i && req_i.opcode == gap_pkg::OP_SEARCH) begin
          state_d = off_grid ? gap_pkg::ST_STATUS : gap_pkg::ST_CLEAR;
        end
      end
      gap_pkg::ST_CLEAR: begin
        if (idx_q == '1) state_d = gap_pkg::ST_SEED;
      end
      gap_pkg::ST_SEED: state_d = gap_pkg::ST_POP;
      gap_pkg::ST_POP: begin
        if (heap_sts_i.idle) begin
          state_d = heap_sts_i.empty ? gap_pkg::ST_STATUS : gap_pkg::ST_POP_WAIT;
        end
      end
      gap_pkg::ST_POP_WAIT: begin
        if (heap_sts_i.idle) begin
          state_d = (heap_root_i == goal_q) ? gap_pkg::ST_BT_GOAL : gap_pkg::ST_CUR_RD;
        end
      end
      gap_pkg::ST_CUR_RD: state_d = gap_pkg::ST_CUR_WR;
      gap_pkg::ST_CUR_WR: state_d = gap_pkg::ST_NB_RD;
      gap_pkg::ST_NB_RD: begin
        if (nb_ok) begin
          state_d = gap_pkg::ST_NB_CHK;
        end else if (last_dir) begin
          state_d = gap_pkg::ST_POP;
        end
      end
      gap_pkg::ST_NB_CHK: begin
        if (relax) begin
          state_d = gap_pkg::ST_PUSH_WAIT;
        end else begin
          state_d = last_dir ? gap_pkg::ST_POP : gap_pkg::ST_NB_RD;
        end
      end
      gap_pkg::ST_PUSH_WAIT: begin
        if (heap_sts_i.idle) begin
          if (heap_sts_i.full) begin
            state_d = gap_pkg::ST_STATUS;
          end else begin
            state_d = last_dir ? gap_pkg::ST_POP : gap_pkg::ST_NB_RD;
          end
        end
      end
      gap_pkg::ST_BT_GOAL: begin
        if (res_ready_i) begin
          state_d = (goal_q == start_q) ? gap_pkg::ST_BT_START : gap_pkg::ST_BT_RD;
        end
      end
      gap_pkg::ST_BT_RD:  state_d = gap_pkg::ST_BT_CHK;
      gap_pkg::ST_BT_CHK: state_d = emit_turn ? gap_pkg::ST_BT_TURN : gap_pkg::ST_BT_ADV;
      gap_pkg::ST_BT_TURN: begin
        if (res_ready_i) state_d = gap_pkg::ST_BT_ADV;
      end
      gap_pkg::ST_BT_ADV: begin
        if (prev_q == start_q || steps_q + SW'(1) == SW'(CELLS)) begin
          state_d = gap_pkg::ST_BT_START;
        end else begin
          state_d = gap_pkg::ST_BT_RD;
        end
      end
      gap_pkg::ST_BT_START: begin
        if (res_ready_i) state_d = gap_pkg::ST_IDLE;
      end
      gap_pkg::ST_STATUS: begin
        if (res_ready_i) state_d = gap_pkg::ST_IDLE;
      end
      default: state_d = gap_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory ports
  always_comb begin
    req_ready_o  = (state_q == gap_pkg::ST_IDLE);
    grid_we      = 1'b0;
    grid_wa      = idx_q;
    grid_wd      = 1'b0;
    node_we      = 1'b0;
    node_wa      = idx_q;
    node_wd      = {1'b0, COST_INF, AW'(0)};
    node_ra      = (state_q == gap_pkg::ST_NB_RD) ? nb_addr : cur_q;
    heap_cmd_o   = '0;
    heap_wdata_o = {f_q, nb_q};
    res_o        = '0;
    case (state_q)
      gap_pkg::ST_INIT: grid_we = 1'b1;
      gap_pkg::ST_IDLE: begin
        if (accept && req_i.opcode == gap_pkg::OP_LOAD && load_ok) begin
          grid_we = 1'b1;
          grid_wa = {cr8[RW-1:0], cc8[CW-1:0]};
          grid_wd = req_i.cell_blocked;
        end
        heap_cmd_o.clear = accept && req_i.opcode == gap_pkg::OP_SEARCH;
      end
      gap_pkg::ST_CLEAR: node_we = 1'b1;
      gap_pkg::ST_SEED: begin
        node_we         = 1'b1;
        node_wa         = start_q;
        node_wd         = {1'b0, COST_W'(0), AW'(0)};
        heap_cmd_o.push = 1'b1;
        heap_wdata_o    = {manh(start_q, goal_q), start_q};
      end
      gap_pkg::ST_POP: heap_cmd_o.pop = heap_sts_i.idle && !heap_sts_i.empty;
      gap_pkg::ST_CUR_WR: begin
        node_we = 1'b1;
        node_wa = cur_q;
        node_wd = {1'b1, rd_cost, rd_pred};
      end
      gap_pkg::ST_NB_CHK: begin
        node_we = relax;
        node_wa = nb_q;
        node_wd = {1'b0, g_new, cur_q};
      end
      gap_pkg::ST_PUSH_WAIT: heap_cmd_o.push = heap_sts_i.idle && !heap_sts_i.full;
      gap_pkg::ST_BT_GOAL: begin
        res_o.valid     = 1'b1;
        res_o.point_row = 4'(goal_q[AW-1 -: RW]);
        res_o.point_col = 4'(goal_q[CW-1:0]);
        res_o.status    = gap_pkg::STATUS_FOUND;
      end
      gap_pkg::ST_BT_TURN: begin
        res_o.valid     = 1'b1;
        res_o.point_row = 4'(cur_r);
        res_o.point_col = 4'(cur_c);
        res_o.status    = gap_pkg::STATUS_FOUND;
      end
      gap_pkg::ST_BT_START: begin
        res_o.valid     = 1'b1;
        res_o.point_row = 4'(start_q[AW-1 -: RW]);
        res_o.point_col = 4'(start_q[CW-1:0]);
        res_o.status    = gap_pkg::STATUS_FOUND;
        res_o.last      = 1'b1;
      end
      gap_pkg::ST_STATUS: begin
        res_o.valid  = 1'b1;
        res_o.status = status_q;
        res_o.last   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (grid_we) begin
      grid_mem[grid_wa] <= grid_wd;
    end
    grid_rd_q <= grid_mem[nb_addr];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    node_rd_q <= node_mem[node_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gap_pkg::ST_INIT;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == gap_pkg::ST_INIT || state_q == gap_pkg::ST_CLEAR) begin
        idx_q <= idx_q + AW'(1);
      end else if (accept) begin
        idx_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      gap_pkg::ST_IDLE: begin
        if (accept) begin
          start_q  <= s_addr;
          goal_q   <= g_addr;
          status_q <= gap_pkg::STATUS_NO_PATH;
        end
      end
      gap_pkg::ST_POP_WAIT: begin
        if (heap_sts_i.idle) cur_q <= heap_root_i;
      end
      gap_pkg::ST_CUR_WR: begin
        gcur_q <= rd_cost;
        d_q    <= gap_pkg::DIR_UP;
      end
      gap_pkg::ST_NB_RD: begin
        nb_q <= nb_addr;
        if (!nb_ok) d_q <= d_q + 2'd1;
      end
      gap_pkg::ST_NB_CHK: begin
        f_q <= F_W'(g_new) + manh(nb_q, goal_q);
        if (!relax) d_q <= d_q + 2'd1;
      end
      gap_pkg::ST_PUSH_WAIT: begin
        if (heap_sts_i.idle) begin
          d_q <= d_q + 2'd1;
          if (heap_sts_i.full) status_q <= gap_pkg::STATUS_OVERFLOW;
        end
      end
      gap_pkg::ST_BT_GOAL: begin
        n_q     <= TW'(1);
        xf_q    <= 1'b0;
        yf_q    <= 1'b0;
        steps_q <= '0;
      end
      gap_pkg::ST_BT_CHK: begin
        prev_q <= rd_pred;
        xf_q   <= xf_n;
        yf_q   <= yf_n;
      end
      gap_pkg::ST_BT_TURN: begin
        if (res_ready_i) n_q <= n_q + TW'(1);
      end
      gap_pkg::ST_BT_ADV: begin
        cur_q   <= prev_q;
        steps_q <= steps_q + SW'(1);
      end
      default: ;
    endcase
  end

  a_heap_cmd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (heap_cmd_o.push || heap_cmd_o.pop) |-> heap_sts_i.idle)
    else $error("heap command while heap busy");

  a_bt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gap_pkg::ST_BT_ADV) |-> (steps_q < SW'(CELLS)))
    else $error("backtrack ran past cell count");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.last && res_ready_i) |=> (state_q == gap_pkg::ST_IDLE))
    else $error("search did not end on last word");

endmodule

FILE: hdl/grid_astar_path_turns.sv
// Load: one word per cycle while no search runs. Search: one node clear sweep over all
// 2^(clog2 rows + clog2 cols) entries (256 at 16x16), then expansion of each popped
// node with a heap sift level by level, then a backtrack from goal to start; one search
// at a time. Results leave through an output register that takes a new word in the same
// cycle as its held word drains. Reset: asynchronous, active low; afterwards the obstacle
// map is swept free, one entry per cycle, while in_i.ready stays low.
`timescale 1ns / 1ps

module grid_astar_path_turns #(
  parameter int GRID_ROWS       = 16,
  parameter int GRID_COLS       = 16,
  parameter int HEAP_DEPTH      = 1024,
  parameter int MAX_TURN_POINTS = 25
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gap_in_if.sink    in_i,
  gap_out_if.source out_o
);

  localparam int AW     = $clog2(GRID_ROWS) + $clog2(GRID_COLS);
  localparam int CELLS  = GRID_ROWS * GRID_COLS;
  localparam int COST_W = $clog2(CELLS) + 1;
  localparam int F_W    = COST_W + 1;
  localparam int EW     = F_W + AW;

  gap_pkg::gap_req_t      req;
  gap_pkg::gap_res_t      res;
  gap_pkg::gap_heap_cmd_t heap_cmd;
  gap_pkg::gap_heap_sts_t heap_sts;
  logic [EW-1:0]          heap_wdata;
  logic [AW-1:0]          heap_root;
  logic                   req_ready, res_ready;

  logic       out_valid_q;
  logic [3:0] out_row_q, out_col_q;
  logic [1:0] out_status_q;
  logic       out_last_q;

  assign req.opcode       = in_i.opcode;
  assign req.cell_row     = in_i.cell_row;
  assign req.cell_col     = in_i.cell_col;
  assign req.cell_blocked = in_i.cell_blocked;
  assign req.start_row    = in_i.start_row;
  assign req.start_col    = in_i.start_col;
  assign req.goal_row     = in_i.goal_row;
  assign req.goal_col     = in_i.goal_col;
  assign in_i.ready       = req_ready;

  gap_search #(
    .GRID_ROWS       (GRID_ROWS),
    .GRID_COLS       (GRID_COLS),
    .MAX_TURN_POINTS (MAX_TURN_POINTS)
  ) u_search (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .req_valid_i  (in_i.valid),
    .req_ready_o  (req_ready),
    .res_o        (res),
    .res_ready_i  (res_ready),
    .heap_cmd_o   (heap_cmd),
    .heap_wdata_o (heap_wdata),
    .heap_root_i  (heap_root),
    .heap_sts_i   (heap_sts)
  );

  gap_heap #(
    .DEPTH  (HEAP_DEPTH),
    .F_W    (F_W),
    .CELL_W (AW)
  ) u_heap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (heap_cmd),
    .wdata_i (heap_wdata),
    .root_o  (heap_root),
    .sts_o   (heap_sts)
  );

  // take a new word when the register is empty or drains this cycle
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_row_q    <= res.point_row;
      out_col_q    <= res.point_col;
      out_status_q <= res.status;
      out_last_q   <= res.last;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.point_row = out_row_q;
  assign out_o.point_col = out_col_q;
  assign out_o.status    = out_status_q;
  assign out_o.last      = out_last_q;

endmodule
